>>> design/ccrp_pkg.sv
// ----------------------------------------------------------------------------
// ccrp_pkg
// Shared types and constants for the CRC-checked record parser.
// ----------------------------------------------------------------------------
package ccrp_pkg;

  localparam logic [5:0]  REC_LEN     = 6'd46;
  localparam logic [5:0]  POS_MAGIC_L = 6'd0;
  localparam logic [5:0]  POS_MAGIC_H = 6'd1;
  localparam logic [5:0]  POS_VERSION = 6'd2;
  localparam logic [5:0]  POS_SEALED  = 6'd3;
  localparam logic [5:0]  POS_CRC_LO  = 6'd4;
  localparam logic [5:0]  POS_CRC_HI  = 6'd7;
  localparam logic [5:0]  POS_ANC_LO  = 6'd8;
  localparam logic [5:0]  POS_ANC_HI  = 6'd37;

  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_PRESET  = 32'hFFFF_FFFF;
  localparam logic [15:0] SOFT_MAGIC  = 16'hF00C;
  localparam logic [7:0]  SOFT_VER_A  = 8'h01;
  localparam logic [7:0]  SOFT_VER_B  = 8'h02;

  localparam logic [3:0]  IDX_MAX     = 4'd14;

  localparam logic        KIND_ANCHOR  = 1'b0;
  localparam logic        KIND_VERDICT = 1'b1;

  localparam logic [1:0]  ST_CRC_OK   = 2'd0;
  localparam logic [1:0]  ST_SOFT     = 2'd1;
  localparam logic [1:0]  ST_REJECT   = 2'd2;
  localparam logic [1:0]  ST_SHORT    = 2'd3;

  typedef struct packed {
    logic               kind;
    logic [3:0]         value_index;
    logic signed [15:0] anchor_value;
    logic [1:0]         status;
    logic [15:0]        magic_word;
    logic [7:0]         version_byte;
    logic [7:0]         sealed_byte;
    logic [31:0]        stored_crc;
    logic [31:0]        computed_crc;
  } res_t;

endpackage

>>> design/ccrp_crc_byte.sv
// ----------------------------------------------------------------------------
// ccrp_crc_byte
// One byte of reflected CRC-32, unrolled over the eight bit steps.
// ----------------------------------------------------------------------------
module ccrp_crc_byte (
  input  logic [31:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] crc_o
);
  import ccrp_pkg::*;

  always_comb begin
    logic [31:0] c;
    c = crc_i ^ {24'd0, byte_i};
    for (int k = 0; k < 8; k++) begin
      c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
    end
    crc_o = c;
  end

endmodule

>>> design/ccrp_parser.sv
// ----------------------------------------------------------------------------
// ccrp_parser
// Record state, field capture and result formation for one byte beat.
// ----------------------------------------------------------------------------
module ccrp_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            consume_i,
  input  logic [7:0]      byte_i,
  input  logic            eom_i,
  output logic            produces_o,
  output ccrp_pkg::res_t  res_o
);
  import ccrp_pkg::*;

  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] cap_crc_r, cap_crc_nxt;
  logic [15:0] magic_r, magic_nxt;
  logic [7:0]  version_r, version_nxt;
  logic [7:0]  sealed_r, sealed_nxt;
  logic [7:0]  pend_r, pend_nxt;

  logic [5:0]  upd_pos;
  logic [31:0] upd_crc;
  logic [31:0] upd_cap_crc;
  logic [15:0] upd_magic;
  logic [7:0]  upd_version;
  logic [7:0]  upd_sealed;
  logic [7:0]  upd_pend;

  logic        in_rec;
  logic        crc_zone;
  logic        anc_zone;
  logic        anchor;
  logic [5:0]  anc_off;
  logic [7:0]  crc_feed;
  logic [31:0] crc_step;
  logic [31:0] calc;

  assign in_rec   = pos_r < REC_LEN;
  assign crc_zone = (pos_r >= POS_CRC_LO) && (pos_r <= POS_CRC_HI);
  assign anc_zone = (pos_r >= POS_ANC_LO) && (pos_r <= POS_ANC_HI);
  assign crc_feed = crc_zone ? 8'd0 : byte_i;
  assign anc_off  = pos_r - POS_ANC_LO;

  ccrp_crc_byte u_crc (
    .crc_i  (crc_r),
    .byte_i (crc_feed),
    .crc_o  (crc_step)
  );

  always_comb begin
    upd_pos     = pos_r;
    upd_crc     = crc_r;
    upd_cap_crc = cap_crc_r;
    upd_magic   = magic_r;
    upd_version = version_r;
    upd_sealed  = sealed_r;
    upd_pend    = pend_r;
    anchor      = 1'b0;

    if (in_rec) begin
      upd_crc = crc_step;
      upd_pos = pos_r + 6'd1;
      case (pos_r)
        POS_MAGIC_L: upd_magic[7:0]  = byte_i;
        POS_MAGIC_H: upd_magic[15:8] = byte_i;
        POS_VERSION: upd_version     = byte_i;
        POS_SEALED:  upd_sealed      = byte_i;
        default: begin
          if (crc_zone) begin
            case (pos_r[1:0])
              2'd0:    upd_cap_crc[7:0]   = byte_i;
              2'd1:    upd_cap_crc[15:8]  = byte_i;
              2'd2:    upd_cap_crc[23:16] = byte_i;
              default: upd_cap_crc[31:24] = byte_i;
            endcase
          end else if (anc_zone) begin
            if (!pos_r[0]) begin
              upd_pend = byte_i;
            end else begin
              anchor = 1'b1;
            end
          end
        end
      endcase
    end

    calc = ~upd_crc;

    res_o = '0;
    if (eom_i) begin
      res_o.kind         = KIND_VERDICT;
      res_o.magic_word   = upd_magic;
      res_o.version_byte = upd_version;
      res_o.sealed_byte  = upd_sealed;
      if (upd_pos < REC_LEN) begin
        res_o.status = ST_SHORT;
      end else begin
        res_o.stored_crc   = upd_cap_crc;
        res_o.computed_crc = calc;
        if (calc == upd_cap_crc) begin
          res_o.status = ST_CRC_OK;
        end else if (upd_magic == SOFT_MAGIC &&
                     (upd_version == SOFT_VER_A || upd_version == SOFT_VER_B)) begin
          res_o.status = ST_SOFT;
        end else begin
          res_o.status = ST_REJECT;
        end
      end
    end else if (anchor) begin
      res_o.kind         = KIND_ANCHOR;
      res_o.value_index  = anc_off[4:1];
      res_o.anchor_value = {byte_i, pend_r};
    end
    produces_o = eom_i || anchor;

    // end of message drops back to the start of a fresh record
    if (eom_i) begin
      pos_nxt     = 6'd0;
      crc_nxt     = CRC_PRESET;
      cap_crc_nxt = 32'd0;
      magic_nxt   = 16'd0;
      version_nxt = 8'd0;
      sealed_nxt  = 8'd0;
      pend_nxt    = 8'd0;
    end else begin
      pos_nxt     = upd_pos;
      crc_nxt     = upd_crc;
      cap_crc_nxt = upd_cap_crc;
      magic_nxt   = upd_magic;
      version_nxt = upd_version;
      sealed_nxt  = upd_sealed;
      pend_nxt    = upd_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 6'd0;
      crc_r     <= CRC_PRESET;
      cap_crc_r <= 32'd0;
      magic_r   <= 16'd0;
      version_r <= 8'd0;
      sealed_r  <= 8'd0;
      pend_r    <= 8'd0;
    end else if (consume_i) begin
      pos_r     <= pos_nxt;
      crc_r     <= crc_nxt;
      cap_crc_r <= cap_crc_nxt;
      magic_r   <= magic_nxt;
      version_r <= version_nxt;
      sealed_r  <= sealed_nxt;
      pend_r    <= pend_nxt;
    end
  end

endmodule

>>> design/crc_checked_record_parser_core.sv
// ----------------------------------------------------------------------------
// crc_checked_record_parser_core
// Byte-wise parser of a 46-byte record with CRC-32 check, anchor values out.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  data_byte, end_of_message
//   out_     output     out_valid/out_stall  kind, index, value, verdict fields
//
// One byte beat per cycle is sustained while results can leave; a beat waits
// in the input register until consumed; its result goes to the output register.
// The byte-wide CRC update and field capture sit between those two registers.
// Reset is synchronous on rst_n and returns the parser to the record start.
// A stalled output holds its beat; input keeps flowing while bytes that make
// no result can pass, and in_stall rises only when a result has nowhere to go.
// ----------------------------------------------------------------------------
module crc_checked_record_parser_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_message,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic [3:0]         out_value_index,
  output logic signed [15:0] out_anchor_value,
  output logic [1:0]         out_status,
  output logic [15:0]        out_magic_word,
  output logic [7:0]         out_version_byte,
  output logic [7:0]         out_sealed_byte,
  output logic [31:0]        out_stored_crc,
  output logic [31:0]        out_computed_crc
);
  import ccrp_pkg::*;

  logic       in_full_r, in_full_nxt;
  logic [7:0] in_byte_r;
  logic       in_eom_r;
  logic       in_accept;
  logic       consume;
  logic       produces;
  logic       out_valid_r, out_valid_nxt;
  res_t       res;
  res_t       out_res_r;

  assign consume   = in_full_r && (!produces || !out_valid_r || !out_stall);
  assign in_stall  = in_full_r && !consume;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (in_accept) begin
      in_full_nxt = 1'b1;
    end else if (consume) begin
      in_full_nxt = 1'b0;
    end else begin
      in_full_nxt = in_full_r;
    end

    if (consume && produces) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  ccrp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .consume_i  (consume),
    .byte_i     (in_byte_r),
    .eom_i      (in_eom_r),
    .produces_o (produces),
    .res_o      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_data_byte;
      in_eom_r  <= in_end_of_message;
    end
    if (consume && produces) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_res_r.kind;
  assign out_value_index  = out_res_r.value_index;
  assign out_anchor_value = out_res_r.anchor_value;
  assign out_status       = out_res_r.status;
  assign out_magic_word   = out_res_r.magic_word;
  assign out_version_byte = out_res_r.version_byte;
  assign out_sealed_byte  = out_res_r.sealed_byte;
  assign out_stored_crc   = out_res_r.stored_crc;
  assign out_computed_crc = out_res_r.computed_crc;

  a_anchor_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ANCHOR |-> out_value_index <= IDX_MAX)
    else $error("anchor index out of range");

  a_short_no_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_VERDICT && out_status == ST_SHORT
    |-> out_stored_crc == 32'd0 && out_computed_crc == 32'd0)
    else $error("short verdict carries crc fields");

  a_held_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_full_r && !consume |=> in_full_r && $stable(in_byte_r) && $stable(in_eom_r))
    else $error("pending input beat lost");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    consume && produces |=> out_valid)
    else $error("result not presented");

endmodule
